FILE: rtl/slfp_pkg.sv
// shared constants of the sync and length frame parser
package slfp_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int LEN_BITS    = 16;
    localparam int PHASE_BITS  = 3;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int SHOW_BITS   = 32;

    // parser phases
    localparam logic [PHASE_BITS-1:0] PH_SYNC1 = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_SYNC2 = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_LENLO = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_LENHI = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_DATA  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PAYLOAD = 2'd2;

    // configuration reset values
    localparam logic [BYTE_BITS-1:0] SYNC_FIRST_RST  = 8'd170;
    localparam logic [BYTE_BITS-1:0] SYNC_SECOND_RST = 8'd85;
    localparam logic [LEN_BITS-1:0]  MAX_PAYLOAD_RST = 16'd1024;

    // dropped byte counts
    localparam logic [2:0] DROP_NONE   = 3'd0;
    localparam logic [2:0] DROP_ONE    = 3'd1;
    localparam logic [2:0] DROP_TWO    = 3'd2;
    localparam logic [2:0] DROP_HEADER = 3'd4;

endpackage

FILE: rtl/sync_length_frame_parser.sv
// sync and length prefixed frame parser with streamed payload and counters
//
//  channel | direction | signals                               | moves
//  in      | to block  | in_valid in_ready rx_byte             | one received word
//  cfg     | to block  | cfg_valid cfg_ready cfg_index cfg_data| one register write
//  out     | from block| out_valid out_ready payload_valid ... | one result word
//
//  one result per input word, through the input register and then the result register
//  sustained rate one word per cycle while the output is not stalled; the header
//  compare and counter step sit between the input register and the result register
//  a stalled output holds the result and the input register; in_ready drops
//  only when both are full and out_ready is low
//  rst_n clears phase, lengths, counters, input and out valid flags, loads config defaults
module sync_length_frame_parser #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [slfp_pkg::BYTE_BITS-1:0]         rx_byte,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [slfp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [slfp_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   payload_valid,
    output logic [slfp_pkg::BYTE_BITS-1:0]         payload_byte,
    output logic                                   frame_last,
    output logic                                   empty_frame,
    output logic [slfp_pkg::SHOW_BITS-1:0]         dropped_count,
    output logic [slfp_pkg::SHOW_BITS-1:0]         frame_count
);

    localparam int ShowBits = (COUNTER_BITS < slfp_pkg::SHOW_BITS) ?
                              COUNTER_BITS : slfp_pkg::SHOW_BITS;

    logic [slfp_pkg::BYTE_BITS-1:0]  sync_first_reg;
    logic [slfp_pkg::BYTE_BITS-1:0]  sync_second_reg;
    logic [slfp_pkg::LEN_BITS-1:0]   max_payload_reg;

    logic                            s1_valid_reg;
    logic [slfp_pkg::BYTE_BITS-1:0]  s1_byte_reg;
    logic                            s1_move;

    logic [slfp_pkg::PHASE_BITS-1:0] phase_reg, phase_next;
    logic [slfp_pkg::LEN_BITS-1:0]   expected_length_reg, expected_length_next;
    logic [slfp_pkg::LEN_BITS-1:0]   received_count_reg, received_count_next;
    logic [COUNTER_BITS-1:0]         dropped_total_reg, dropped_total_next;
    logic [COUNTER_BITS-1:0]         frames_total_reg, frames_total_next;
    logic [2:0]                      drop_n;
    logic                            frame_done;
    logic [slfp_pkg::LEN_BITS-1:0]   full_length;
    logic [slfp_pkg::LEN_BITS-1:0]   count_inc;

    logic                            out_valid_reg;
    logic                            payload_valid_reg, payload_valid_next;
    logic [slfp_pkg::BYTE_BITS-1:0]  payload_byte_reg, payload_byte_next;
    logic                            frame_last_reg, frame_last_next;
    logic                            empty_frame_reg, empty_frame_next;

    assign cfg_ready = 1'b1;
    assign s1_move   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_move;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= slfp_pkg::SYNC_FIRST_RST;
            sync_second_reg <= slfp_pkg::SYNC_SECOND_RST;
            max_payload_reg <= slfp_pkg::MAX_PAYLOAD_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                slfp_pkg::CFG_SYNC_FIRST:
                    sync_first_reg <= cfg_data[slfp_pkg::BYTE_BITS-1:0];
                slfp_pkg::CFG_SYNC_SECOND:
                    sync_second_reg <= cfg_data[slfp_pkg::BYTE_BITS-1:0];
                slfp_pkg::CFG_MAX_PAYLOAD:
                    max_payload_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    assign full_length = {s1_byte_reg, expected_length_reg[slfp_pkg::BYTE_BITS-1:0]};
    assign count_inc   = received_count_reg + slfp_pkg::LEN_BITS'(1);

    // per word parse step
    always_comb
    begin
        phase_next           = phase_reg;
        expected_length_next = expected_length_reg;
        received_count_next  = received_count_reg;
        drop_n               = slfp_pkg::DROP_NONE;
        frame_done           = 1'b0;
        payload_valid_next   = 1'b0;
        payload_byte_next    = '0;
        frame_last_next      = 1'b0;
        empty_frame_next     = 1'b0;
        unique case (phase_reg)
            slfp_pkg::PH_SYNC2:
            begin
                if (s1_byte_reg == sync_second_reg)
                begin
                    phase_next = slfp_pkg::PH_LENLO;
                end
                else if (s1_byte_reg == sync_first_reg)
                begin
                    drop_n = slfp_pkg::DROP_ONE;
                end
                else
                begin
                    drop_n     = slfp_pkg::DROP_TWO;
                    phase_next = slfp_pkg::PH_SYNC1;
                end
            end
            slfp_pkg::PH_LENLO:
            begin
                expected_length_next = {{slfp_pkg::BYTE_BITS{1'b0}}, s1_byte_reg};
                phase_next           = slfp_pkg::PH_LENHI;
            end
            slfp_pkg::PH_LENHI:
            begin
                received_count_next = '0;
                if (full_length > max_payload_reg)
                begin
                    drop_n               = slfp_pkg::DROP_HEADER;
                    phase_next           = slfp_pkg::PH_SYNC1;
                    expected_length_next = '0;
                end
                else if (full_length == '0)
                begin
                    frame_last_next      = 1'b1;
                    empty_frame_next     = 1'b1;
                    frame_done           = 1'b1;
                    phase_next           = slfp_pkg::PH_SYNC1;
                    expected_length_next = '0;
                end
                else
                begin
                    expected_length_next = full_length;
                    phase_next           = slfp_pkg::PH_DATA;
                end
            end
            slfp_pkg::PH_DATA:
            begin
                payload_valid_next  = 1'b1;
                payload_byte_next   = s1_byte_reg;
                received_count_next = count_inc;
                if (count_inc == expected_length_reg)
                begin
                    frame_last_next      = 1'b1;
                    frame_done           = 1'b1;
                    phase_next           = slfp_pkg::PH_SYNC1;
                    expected_length_next = '0;
                    received_count_next  = '0;
                end
            end
            default:
            begin
                if (s1_byte_reg == sync_first_reg)
                begin
                    phase_next = slfp_pkg::PH_SYNC2;
                end
                else
                begin
                    phase_next = slfp_pkg::PH_SYNC1;
                    drop_n     = slfp_pkg::DROP_ONE;
                end
            end
        endcase
        dropped_total_next = dropped_total_reg + COUNTER_BITS'(drop_n);
        frames_total_next  = frames_total_reg + COUNTER_BITS'(frame_done);
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= slfp_pkg::PH_SYNC1;
            expected_length_reg <= '0;
            received_count_reg  <= '0;
            dropped_total_reg   <= '0;
            frames_total_reg    <= '0;
        end
        else if (s1_move)
        begin
            phase_reg           <= phase_next;
            expected_length_reg <= expected_length_next;
            received_count_reg  <= received_count_next;
            dropped_total_reg   <= dropped_total_next;
            frames_total_reg    <= frames_total_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            payload_valid_reg <= payload_valid_next;
            payload_byte_reg  <= payload_byte_next;
            frame_last_reg    <= frame_last_next;
            empty_frame_reg   <= empty_frame_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_valid = payload_valid_reg;
    assign payload_byte  = payload_byte_reg;
    assign frame_last    = frame_last_reg;
    assign empty_frame   = empty_frame_reg;
    assign dropped_count = slfp_pkg::SHOW_BITS'(dropped_total_reg[ShowBits-1:0]);
    assign frame_count   = slfp_pkg::SHOW_BITS'(frames_total_reg[ShowBits-1:0]);

    // checks
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == slfp_pkg::PH_SYNC1 || phase_reg == slfp_pkg::PH_SYNC2 ||
        phase_reg == slfp_pkg::PH_LENLO || phase_reg == slfp_pkg::PH_LENHI ||
        phase_reg == slfp_pkg::PH_DATA)
        else $error("parser phase left the legal set");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == slfp_pkg::PH_DATA |->
        expected_length_reg != '0 && received_count_reg < expected_length_reg)
        else $error("payload count passed the frame length");

    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && empty_frame_next |-> frame_last_next && !payload_valid_next)
        else $error("empty frame result without last mark or with payload");

    a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && frame_last_next |=>
        frames_total_reg == $past(frames_total_reg) + COUNTER_BITS'(1))
        else $error("frame counter did not step on a completed frame");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_move |=> $stable(phase_reg) && $stable(dropped_total_reg))
        else $error("parser state moved without a word");

endmodule
